FILE: rtl/core/rbmm_pkg.sv
// Shared constants for the row-block matrix multiply.
`default_nettype none

package rbmm_pkg;

    // Default sizing of the block.
    localparam int MAX_N_DEF  = 16;
    localparam int ELEM_W_DEF = 16;

    // Fixed field widths of the result and configuration channels.
    localparam int SUM_W      = 36;
    localparam int IDX_W      = 4;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 2;

    // Upper bound on rows per block and the reset value of both registers.
    localparam int               ROWS_LIMIT = 16;
    localparam logic [CFG_W-1:0] CFG_RESET  = 5'd16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_BLOCK = 2'd1;

    // Input item operation codes.
    localparam logic OP_LOAD_B   = 1'b0;
    localparam logic OP_STREAM_A = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/rbmm_if.sv
// Channel interfaces of the row-block matrix multiply: input, result and configuration.
`default_nettype none

interface rbmm_in_if #(
    parameter int ELEM_WIDTH = rbmm_pkg::ELEM_W_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [ELEM_WIDTH-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface rbmm_out_if;
    import rbmm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] c_value;
    logic [IDX_W-1:0]        c_row;
    logic [IDX_W-1:0]        c_col;
    logic                    last_of_row;
    logic                    last_of_block;

    modport source (output valid, output c_value, output c_row, output c_col,
                    output last_of_row, output last_of_block, input ready);
    modport sink   (input valid, input c_value, input c_row, input c_col,
                    input last_of_row, input last_of_block, output ready);
endinterface

interface rbmm_cfg_if;
    import rbmm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/row_block_matrix_multiply.sv
// Row-block matrix multiply top level: B store, column sums and a shared multiply-accumulate.
//
// Channel  Dir  Payload                                         Accepted when
// i_in     in   op, value                                       valid & ready
// o_out    out  c_value, c_row, c_col, last_of_row, last_of_block  valid & ready
// i_cfg    in   index, data                                     valid & ready (always ready)
//
// A B element is stored without holding off the input. An A element holds off the input
// while it is worked: one multiply-accumulate per output column through the single read
// port of the column-sum memory, then the pipeline drains. The A element that ends a row
// then emits N items, each read in S_EMIT_RD and loaded in S_EMIT_LD, which waits while
// o_out stalls; the last item waits in the output register while new items are taken.
// Reset is synchronous; each column sum has a valid bit, so no clearing pass is needed.
`default_nettype none

module row_block_matrix_multiply #(
    parameter int MAX_N      = rbmm_pkg::MAX_N_DEF,
    parameter int ELEM_WIDTH = rbmm_pkg::ELEM_W_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rbmm_in_if.sink     i_in,
    rbmm_out_if.source  o_out,
    rbmm_cfg_if.sink    i_cfg
);
    import rbmm_pkg::*;

    localparam int NW = $clog2(MAX_N + 1);
    localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int AW = $clog2(MAX_N * MAX_N);
    localparam int PW = 2 * ELEM_WIDTH;
    localparam int XW = (PW > SUM_W) ? PW : SUM_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // Control state.
    t_state            r_state;
    logic [CFG_W-1:0]  r_size;
    logic [CFG_W-1:0]  r_rows;
    logic [AW-1:0]     r_b_cnt;
    logic [NW-1:0]     r_a_col;
    logic [AW-1:0]     r_a_base;
    logic [IDX_W-1:0]  r_a_row;
    logic [AW-1:0]     r_item_base;
    logic              r_row_done;
    logic [IDX_W-1:0]  r_emit_row;
    logic              r_emit_last_blk;
    logic [NW-1:0]     r_j;
    logic              r_s1_vld;
    logic              r_s2_vld;
    logic [CW-1:0]     r_s1_col;
    logic [CW-1:0]     r_s2_col;
    logic [MAX_N-1:0]  r_sum_vld;

    // Output register.
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_out_value;
    logic [IDX_W-1:0]        r_out_row;
    logic [IDX_W-1:0]        r_out_col;
    logic                    r_out_last_row;
    logic                    r_out_last_blk;

    // Datapath registers and memories.
    logic signed [ELEM_WIDTH-1:0] r_a;
    logic signed [ELEM_WIDTH-1:0] r_b_rd;
    logic signed [SUM_W-1:0]      r_sum_rd;
    logic                         r_sum_rd_vld;
    logic signed [PW-1:0]         r_prod;
    logic signed [SUM_W-1:0]      r_sum_d;
    logic signed [ELEM_WIDTH-1:0] r_b_mem   [MAX_N*MAX_N];
    logic signed [SUM_W-1:0]      r_sum_mem [MAX_N];

    logic [NW-1:0]           w_n;
    logic [CFG_W-1:0]        w_rows;
    logic [2*NW-1:0]         w_nn;
    logic                    w_in_acc;
    logic                    w_out_acc;
    logic                    w_cfg_hit;
    logic [CW-1:0]           w_j_col;
    logic                    w_issue;
    logic                    w_sum_rd_en;
    logic [AW-1:0]           w_b_addr;
    logic                    w_last_col;
    logic                    w_out_free;
    logic                    w_a_row_done;
    logic                    w_blk_end;
    logic signed [XW-1:0]    w_prod_x;
    logic signed [SUM_W-1:0] w_sum_new;
    logic signed [SUM_W-1:0] w_emit_val;

    // Effective dimension and rows per block, with out-of-range values clamped.
    always_comb begin
        if (r_size == '0) begin
            w_n = NW'(1);
        end else if (32'(r_size) > MAX_N) begin
            w_n = NW'(MAX_N);
        end else begin
            w_n = NW'(r_size);
        end
        if (r_rows == '0) begin
            w_rows = CFG_W'(1);
        end else if (32'(r_rows) > ROWS_LIMIT) begin
            w_rows = CFG_W'(ROWS_LIMIT);
        end else begin
            w_rows = r_rows;
        end
    end

    assign w_nn = (2*NW)'(w_n) * (2*NW)'(w_n);

    // Handshakes.
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign w_cfg_hit = i_cfg.valid && i_cfg.ready &&
                       (i_cfg.index == REG_SIZE_IN_USE || i_cfg.index == REG_ROWS_IN_BLOCK);

    // Sequencer decode.
    assign w_j_col      = r_j[CW-1:0];
    assign w_issue      = (r_state == S_ACC) && (r_j < w_n);
    assign w_sum_rd_en  = w_issue || (r_state == S_EMIT_RD);
    assign w_b_addr     = r_item_base + AW'(r_j);
    assign w_last_col   = (r_j == w_n - NW'(1));
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_a_row_done = (r_a_col == w_n - NW'(1));
    assign w_blk_end    = ({1'b0, r_a_row} == w_rows - CFG_W'(1));

    // Accumulate: sign-extended product added modulo 2^SUM_W.
    assign w_prod_x   = XW'(r_prod);
    assign w_sum_new  = r_sum_d + w_prod_x[SUM_W-1:0];
    assign w_emit_val = r_sum_rd_vld ? r_sum_rd : '0;

    // Sequencer, counters, valid bits and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_size          <= CFG_RESET;
            r_rows          <= CFG_RESET;
            r_b_cnt         <= '0;
            r_a_col         <= '0;
            r_a_base        <= '0;
            r_a_row         <= '0;
            r_item_base     <= '0;
            r_row_done      <= 1'b0;
            r_emit_row      <= '0;
            r_emit_last_blk <= 1'b0;
            r_j             <= '0;
            r_s1_vld        <= 1'b0;
            r_s2_vld        <= 1'b0;
            r_s1_col        <= '0;
            r_s2_col        <= '0;
            r_sum_vld       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            // Pipeline stage tracking for the multiply-accumulate.
            r_s1_vld <= w_issue;
            r_s1_col <= w_j_col;
            r_s2_vld <= r_s1_vld;
            r_s2_col <= r_s1_col;

            if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (r_s2_vld) begin
                r_sum_vld[r_s2_col] <= 1'b1;
            end

            // A register write clears the load and stream counters and the sum valid bits; B contents stay.
            if (w_cfg_hit) begin
                if (i_cfg.index == REG_SIZE_IN_USE) begin
                    r_size <= i_cfg.data;
                end else begin
                    r_rows <= i_cfg.data;
                end
                r_b_cnt   <= '0;
                r_a_col   <= '0;
                r_a_base  <= '0;
                r_a_row   <= '0;
                r_sum_vld <= '0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.op == OP_LOAD_B) begin
                            if (32'(r_b_cnt) + 32'd1 >= 32'(w_nn)) begin
                                r_b_cnt <= '0;
                            end else begin
                                r_b_cnt <= r_b_cnt + AW'(1);
                            end
                        end else begin
                            r_item_base <= r_a_base;
                            r_row_done  <= w_a_row_done;
                            r_j         <= '0;
                            r_state     <= S_ACC;
                            if (w_a_row_done) begin
                                r_a_col         <= '0;
                                r_a_base        <= '0;
                                r_emit_row      <= r_a_row;
                                r_emit_last_blk <= w_blk_end;
                                r_a_row         <= w_blk_end ? '0 : r_a_row + IDX_W'(1);
                            end else begin
                                r_a_col  <= r_a_col + NW'(1);
                                r_a_base <= r_a_base + AW'(w_n);
                            end
                        end
                    end
                end
                S_ACC: begin
                    if (w_issue) begin
                        r_j <= r_j + NW'(1);
                    end else if (!r_s1_vld && !r_s2_vld) begin
                        r_j     <= '0;
                        r_state <= r_row_done ? S_EMIT_RD : S_IDLE;
                    end
                end
                S_EMIT_RD: begin
                    // The sum is read this cycle and returns to zero.
                    r_sum_vld[w_j_col] <= 1'b0;
                    r_state            <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_value    <= w_emit_val;
                        r_out_row      <= r_emit_row;
                        r_out_col      <= IDX_W'(r_j);
                        r_out_last_row <= w_last_col;
                        r_out_last_blk <= w_last_col && r_emit_last_blk;
                        if (w_last_col) begin
                            r_j     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + NW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // B store: written on each B item, read once per issued column.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.op == OP_LOAD_B) begin
            r_b_mem[r_b_cnt] <= i_in.value;
        end
        if (w_issue) begin
            r_b_rd <= r_b_mem[w_b_addr];
        end
    end

    // Column sums: one read port for accumulate and emit, one write port.
    always_ff @(posedge i_clk) begin
        if (w_sum_rd_en) begin
            r_sum_rd     <= r_sum_mem[w_j_col];
            r_sum_rd_vld <= r_sum_vld[w_j_col];
        end
        if (r_s2_vld) begin
            r_sum_mem[r_s2_col] <= w_sum_new;
        end
    end

    // Shared multiplier with its result registered ahead of the adder.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.op == OP_STREAM_A) begin
            r_a <= i_in.value;
        end
        r_prod  <= r_a * r_b_rd;
        r_sum_d <= r_sum_rd_vld ? r_sum_rd : '0;
    end

    // Port drive.
    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.c_value       = r_out_value;
    assign o_out.c_row         = r_out_row;
    assign o_out.c_col         = r_out_col;
    assign o_out.last_of_row   = r_out_last_row;
    assign o_out.last_of_block = r_out_last_blk;

endmodule

`default_nettype wire

FILE: rtl/core/rbmm_checker.sv
// Port-level checks for the row-block matrix multiply, bound to the top level.
`default_nettype none

module rbmm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [rbmm_pkg::SUM_W-1:0]    i_c_value,
    input wire logic [rbmm_pkg::IDX_W-1:0]    i_c_col,
    input wire logic                          i_last_of_row,
    input wire logic                          i_last_of_block
);
    import rbmm_pkg::*;

    logic [IDX_W-1:0] r_exp_col;

    // Expected column of the next result item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_col <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_exp_col <= i_last_of_row ? '0 : r_exp_col + IDX_W'(1);
        end
    end

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_c_value) && $stable(i_c_col))
        else $error("result item changed while stalled");

    // Columns of a row arrive in order from zero.
    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |-> i_c_col == r_exp_col)
        else $error("result column out of sequence");

    // The end of a block is always the end of a row.
    a_blk_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_of_block |-> i_last_of_row)
        else $error("last_of_block without last_of_row");

    // No input item is taken while a row is still being emitted.
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_of_row |-> !i_in_ready)
        else $error("input ready in the middle of a row");

endmodule

bind row_block_matrix_multiply rbmm_checker u_rbmm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_c_value       (o_out.c_value),
    .i_c_col         (o_out.c_col),
    .i_last_of_row   (o_out.last_of_row),
    .i_last_of_block (o_out.last_of_block)
);

`default_nettype wire

FILE: sim/rbmm_product_checker.sv
// Checker for the row-block matrix multiply: predicts every product item and compares it.
`timescale 1ns / 1ps

module rbmm_product_checker #(
    parameter int MAX_N      = rbmm_pkg::MAX_N_DEF,
    parameter int ELEM_WIDTH = rbmm_pkg::ELEM_W_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel.
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic                                 i_in_op,
    input  logic signed [ELEM_WIDTH-1:0]         i_in_value,
    // Result channel.
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [rbmm_pkg::SUM_W-1:0]    i_c_value,
    input  logic [rbmm_pkg::IDX_W-1:0]           i_c_row,
    input  logic [rbmm_pkg::IDX_W-1:0]           i_c_col,
    input  logic                                 i_last_of_row,
    input  logic                                 i_last_of_block,
    // Configuration channel.
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [rbmm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rbmm_pkg::CFG_W-1:0]           i_cfg_data,
    // Status for the testbench top.
    output int                                   o_mismatches,
    output int                                   o_pending
);
    import rbmm_pkg::*;

    // One element of a product row as the block should emit it.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    row_end;
        logic                    block_end;
    } t_c_elem;

    // Predicted state of the block.
    logic signed [ELEM_WIDTH-1:0] b_matrix [MAX_N*MAX_N];
    logic signed [SUM_W-1:0]      col_sums [MAX_N];
    logic [8:0]                   b_fill_ptr;
    logic [IDX_W-1:0]             a_col_idx;
    logic [IDX_W-1:0]             a_row_idx;
    logic [CFG_W-1:0]             size_reg;
    logic [CFG_W-1:0]             rows_reg;

    t_c_elem c_pending_q [$];
    int      c_seen;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        c_seen       = 0;
    end

    // Out-of-range register values are clamped to the supported span.
    function automatic int span_of(input logic [CFG_W-1:0] r, input int lim);
        if (r == 0)
            return 1;
        if (int'(r) > lim)
            return lim;
        return int'(r);
    endfunction

    task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                   input logic [SUM_W-1:0] want);
        o_mismatches++;
        $display("ERROR: result %0d %s: got 0x%h, expected 0x%h at %0t",
                 c_seen, what, got, want, $realtime);
    endtask

    task automatic clear_progress();
        for (int j = 0; j < MAX_N; j++)
            col_sums[j] = '0;
        b_fill_ptr = '0;
        a_col_idx  = '0;
        a_row_idx  = '0;
    endtask

    // A register write changes the shape and drops any partial row.
    task automatic apply_write();
        if (i_cfg_index == REG_SIZE_IN_USE) begin
            size_reg = i_cfg_data;
            clear_progress();
        end else if (i_cfg_index == REG_ROWS_IN_BLOCK) begin
            rows_reg = i_cfg_data;
            clear_progress();
        end
    endtask

    // Work out the effect of one accepted input item.
    task automatic predict_item();
        int                      n;
        int                      rows;
        int                      addr;
        logic signed [SUM_W-1:0] a_wide;
        logic signed [SUM_W-1:0] b_wide;
        t_c_elem                 c;

        n    = span_of(size_reg, MAX_N);
        rows = span_of(rows_reg, ROWS_LIMIT);

        if (i_in_op == OP_LOAD_B) begin
            addr = int'(b_fill_ptr) % (n * n);
            b_matrix[addr] = i_in_value;
            b_fill_ptr = (addr + 1 >= n * n) ? '0 : 9'(addr + 1);
        end else begin
            if (int'(a_col_idx) >= n)
                a_col_idx = '0;
            if (int'(a_row_idx) >= rows)
                a_row_idx = '0;
            a_wide = i_in_value;
            for (int j = 0; j < n; j++) begin
                b_wide = b_matrix[int'(a_col_idx) * n + j];
                col_sums[j] = col_sums[j] + a_wide * b_wide;
            end
            if (int'(a_col_idx) == n - 1) begin
                // Row complete: queue one item per column and restart the sums.
                for (int j = 0; j < n; j++) begin
                    c.sum       = col_sums[j];
                    c.row       = a_row_idx;
                    c.col       = IDX_W'(j);
                    c.row_end   = (j == n - 1);
                    c.block_end = (j == n - 1) && (int'(a_row_idx) == rows - 1);
                    c_pending_q.push_back(c);
                    col_sums[j] = '0;
                end
                a_col_idx = '0;
                a_row_idx = (int'(a_row_idx) + 1 >= rows) ? '0 : a_row_idx + 1'b1;
            end else begin
                a_col_idx = a_col_idx + 1'b1;
            end
        end
    endtask

    // Compare one emitted item with the oldest expectation.
    task automatic check_result();
        t_c_elem c;

        c_seen++;
        if (c_pending_q.size() == 0) begin
            report_mismatch("unexpected, c_value", i_c_value, '0);
            return;
        end
        c = c_pending_q.pop_front();
        if (i_c_value !== c.sum)
            report_mismatch("c_value", i_c_value, c.sum);
        if (i_c_row !== c.row)
            report_mismatch("c_row", SUM_W'(i_c_row), SUM_W'(c.row));
        if (i_c_col !== c.col)
            report_mismatch("c_col", SUM_W'(i_c_col), SUM_W'(c.col));
        if (i_last_of_row !== c.row_end)
            report_mismatch("last_of_row", SUM_W'(i_last_of_row), SUM_W'(c.row_end));
        if (i_last_of_block !== c.block_end)
            report_mismatch("last_of_block", SUM_W'(i_last_of_block), SUM_W'(c.block_end));
    endtask

    // Everything is sampled at the rising edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_reg = CFG_RESET;
            rows_reg = CFG_RESET;
            clear_progress();
            c_pending_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                apply_write();
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                predict_item();
        end
        o_pending = c_pending_q.size();
    end

endmodule

FILE: sim/row_block_matrix_multiply_tb.sv
// Testbench top for the row-block matrix multiply: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module row_block_matrix_multiply_tb;
    import rbmm_pkg::*;

    // Register indexes past the end of the register list; writes there are ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Cycles for an A item still in the pipeline to settle.
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEM_TARGET   = 430;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rbmm_in_if #(.ELEM_WIDTH(ELEM_W_DEF)) in_ch ();
    rbmm_out_if                           out_ch ();
    rbmm_cfg_if                           cfg_ch ();

    int mismatches;
    int pending;

    // Idling controls shared by the sender, the receiver and the phase sequencer.
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic hold_req   = 1'b0;

    // Bookkeeping so that no A item ever reads an unwritten B entry.
    int cur_n;
    int cur_rows;
    int b_fill;
    int a_col;
    bit b_known [MAX_N_DEF*MAX_N_DEF];
    int sent_items;

    row_block_matrix_multiply #(
        .MAX_N     (MAX_N_DEF),
        .ELEM_WIDTH(ELEM_W_DEF)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    rbmm_product_checker #(
        .MAX_N     (MAX_N_DEF),
        .ELEM_WIDTH(ELEM_W_DEF)
    ) product_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_in_op        (in_ch.op),
        .i_in_value     (in_ch.value),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_c_value      (out_ch.c_value),
        .i_c_row        (out_ch.c_row),
        .i_c_col        (out_ch.c_col),
        .i_last_of_row  (out_ch.last_of_row),
        .i_last_of_block(out_ch.last_of_block),
        .i_cfg_valid    (cfg_ch.valid),
        .i_cfg_ready    (cfg_ch.ready),
        .i_cfg_index    (cfg_ch.index),
        .i_cfg_data     (cfg_ch.data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result receiver: waits a drawn number of cycles before taking each item.
    initial begin : result_drain
        int gap;

        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            gap = rx_idle_on ? int'($urandom_range(0, 7)) : 0;
            if (hold_req) begin
                // Long hold-off so that the block backs up into its input.
                gap      = 400;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            @(negedge i_clk);
        end
    end

    function automatic int span_of(input logic [CFG_W-1:0] r, input int lim);
        if (r == 0)
            return 1;
        if (int'(r) > lim)
            return lim;
        return int'(r);
    endfunction

    // Matrix element biased toward the extremes.
    function automatic logic signed [ELEM_W_DEF-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            3: return -16'sd1;
            default: return ELEM_W_DEF'($urandom);
        endcase
    endfunction

    // True when every B entry that the next A item reads has been written.
    function automatic bit b_row_known();
        for (int j = 0; j < cur_n; j++)
            if (!b_known[a_col * cur_n + j])
                return 1'b0;
        return 1'b1;
    endfunction

    // Offer one input item and wait until the block takes it.
    task automatic send_item(input logic op, input logic signed [ELEM_W_DEF-1:0] v);
        int gap;

        gap = tx_idle_on ? int'($urandom_range(0, 7)) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic send_b(input logic signed [ELEM_W_DEF-1:0] v);
        send_item(OP_LOAD_B, v);
        b_known[b_fill] = 1'b1;
        b_fill = (b_fill + 1 >= cur_n * cur_n) ? 0 : b_fill + 1;
    endtask

    task automatic send_a(input logic signed [ELEM_W_DEF-1:0] v);
        send_item(OP_STREAM_A, v);
        a_col = (a_col + 1 == cur_n) ? 0 : a_col + 1;
    endtask

    // Let every expected item come out and the pipeline go quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_SIZE_IN_USE)
            cur_n = span_of(data, MAX_N_DEF);
        if (idx == REG_ROWS_IN_BLOCK)
            cur_rows = span_of(data, ROWS_LIMIT);
        if (idx == REG_SIZE_IN_USE || idx == REG_ROWS_IN_BLOCK) begin
            b_fill = 0;
            a_col  = 0;
        end
    endtask

    // Main sequence: directed cases, then random phases.
    initial begin
        int  phase;
        int  a_target;
        int  a_sent;
        int  guard;
        bit  wide_done;
        logic [CFG_W-1:0] size_val;

        in_ch.valid  = 1'b0;
        in_ch.op     = OP_LOAD_B;
        in_ch.value  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SIZE_IN_USE;
        cfg_ch.data  = '0;
        cur_n        = MAX_N_DEF;
        cur_rows     = ROWS_LIMIT;
        b_fill       = 0;
        a_col        = 0;
        sent_items   = 0;
        wide_done    = 1'b0;
        for (int k = 0; k < MAX_N_DEF * MAX_N_DEF; k++)
            b_known[k] = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Zero registers act as one: 1x1 matrix, one row per block.
        write_reg(REG_SIZE_IN_USE, '0);
        write_reg(REG_ROWS_IN_BLOCK, '0);
        send_b(16'sd32767);
        send_a(-16'sd32768);
        // B reload after N*N loads overwrites element (0,0).
        send_b(-16'sd32768);
        send_a(-16'sd32768);
        send_a(16'sd32767);

        // 2x2 with the most negative values: sums pass 32 bits.
        write_reg(REG_SIZE_IN_USE, 5'd2);
        write_reg(REG_ROWS_IN_BLOCK, 5'd31);
        repeat (4) send_b(-16'sd32768);
        send_a(-16'sd32768);
        send_a(-16'sd32768);
        // B load interleaved in the middle of a row.
        send_a(16'sd32767);
        send_b('0);
        send_a(-16'sd1);
        // Partial row dropped by a register write.
        send_a(16'sd12345);
        write_reg(REG_ROWS_IN_BLOCK, 5'd1);
        write_reg(REG_SPARE_HI, 5'd31);
        write_reg(REG_SIZE_IN_USE, 5'd31);
        write_reg(REG_SIZE_IN_USE, 5'd1);
        send_a(-16'sd32768);
        send_b(-16'sd1);
        send_a(-16'sd32768);
        write_reg(REG_SPARE_LO, '0);
        send_a(16'sd32767);

        // Random phases, each under a fresh idling mix and often a new shape; the long receiver
        // hold-off in phase five always takes place.
        phase = 0;
        while (sent_items < ITEM_TARGET || !wide_done || phase < 5) begin
            phase++;
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);

            if (phase == 3) begin
                // The full-size phase; values above the limit act as the limit.
                case ($urandom_range(0, 2))
                    0: size_val = 5'd16;
                    1: size_val = 5'd17;
                    default: size_val = 5'd31;
                endcase
                write_reg(REG_SIZE_IN_USE, size_val);
                wide_done = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                size_val = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(5, 8))
                                                       : CFG_W'($urandom_range(0, 4));
                write_reg(REG_SIZE_IN_USE, size_val);
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_ROWS_IN_BLOCK, ($urandom_range(0, 4) == 0)
                                              ? CFG_W'($urandom_range(0, 31))
                                              : CFG_W'($urandom_range(1, 4)));
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_W'($urandom));

            if (phase == 5) begin
                // Receiver stalls for a long stretch while items keep coming.
                hold_req   = 1'b1;
                tx_idle_on = 1'b0;
            end

            // Usually a fresh B first; otherwise whatever is stored is reused.
            if ($urandom_range(0, 3) != 0)
                repeat (cur_n * cur_n) send_b(rand_elem());

            a_target = $urandom_range(1, 2 * cur_rows * cur_n);
            if (cur_n == MAX_N_DEF && a_target > 3 * cur_n)
                a_target = 3 * cur_n;
            else if (cur_n < MAX_N_DEF && a_target > 40)
                a_target = 40;
            a_sent = 0;
            while (a_sent < a_target) begin
                if ($urandom_range(0, 9) == 0 || !b_row_known()) begin
                    send_b(rand_elem());
                end else begin
                    send_a(rand_elem());
                    a_sent++;
                end
            end
        end

        // Drain what is left, bounded, then allow for stray items.
        in_ch.valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 50000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
